/* hdl/assert_macros.svh */
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion sampled on clk, ignored while rstn is low
`define LJE_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Assertion sampled on clk, checked during reset as well
`define LJE_ASSERT_NR(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

/* hdl/lje_pkg.sv */
// Types and constants of the Lennard-Jones pair energy pipeline
package lje_pkg;

    localparam int D_W = 24;
    localparam int EPS_W = 21;
    localparam int Q_W = 52;
    localparam int X16_W = 36;
    localparam int TM_W = 56;
    localparam int E_W = 40;
    localparam int MAG_W = 61;

    localparam logic [1:0] REG_REPULSIVE = 2'd0;
    localparam logic [1:0] REG_CUTOFF = 2'd1;
    localparam logic [1:0] REG_FLOOR = 2'd2;

    localparam logic [E_W-1:0] E_MAX = {1'b0, {(E_W-1){1'b1}}};
    localparam logic [E_W-1:0] E_MIN = {1'b1, {(E_W-1){1'b0}}};

    typedef struct packed {
        logic             zf;
        logic             big;
        logic             eneg;
        logic             tneg;
        logic [EPS_W-1:0] emag;
        logic [Q_W-1:0]   q;
        logic [X16_W-1:0] x16;
        logic [TM_W-1:0]  tm;
    } side_t;

endpackage

/* hdl/lj_pair_energy.sv */
// Lennard-Jones 12-6 pair energy pipeline, top level
// Throughput: one pair per cycle; the 52-stage divider and five two-stage
// multipliers all advance together and stall as one when the result is held.
// Reset: synchronous active-low aresetn clears all valid bits and the
// configuration registers (repulsive mode off, cutoff 0, floor 0).
module lj_pair_energy
    import lje_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // pair_distance[23:0], radius_sum[47:24], well_depth[68:48]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // pair_energy[39:0]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [23:0] cfg_wdata
);

    logic             rep_reg;
    logic [D_W-1:0]   cut_reg, floor_reg;
    logic             en;

    logic [D_W-1:0]   d, rs, ri;
    logic [EPS_W-1:0] w;
    side_t            side0_next, side0_reg;
    logic [D_W-1:0]   ri0_reg, rs0_reg;
    logic             v0_reg;

    logic             dv_v;
    logic [Q_W-1:0]   dv_q;
    side_t            dv_side, dv_side_q;

    logic             m1_v, m2_v, m3_v, m4_v, m5_v;
    logic [2*Q_W-1:0] m1_p, m2_p, m3_p;
    logic [2*X16_W-1:0] m4_p;
    logic [EPS_W+TM_W-1:0] m5_p;
    side_t            m1_s, m2_s, m3_s, m4_s, m5_s;

    side_t            g1_next, g2_next, g3_next, g4_next;
    side_t            g1_side_reg, g2_side_reg, g3_side_reg, g4_side_reg;
    logic             g1_v_reg, g2_v_reg, g3_v_reg, g4_v_reg;
    logic [Q_W-1:0]   q2_reg, q3_reg;
    logic [TM_W-1:0]  s_val;
    logic [TM_W-1:0]  two;

    logic [MAG_W-1:0] mag;
    logic             neg;
    logic [E_W-1:0]   res;
    logic             m_tvalid_reg;
    logic [E_W-1:0]   m_tdata_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rep_reg   <= 1'b0;
            cut_reg   <= '0;
            floor_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_REPULSIVE: rep_reg   <= cfg_wdata[0];
                REG_CUTOFF:    cut_reg   <= cfg_wdata;
                REG_FLOOR:     floor_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        d  = s_tdata[23:0];
        rs = s_tdata[47:24];
        w  = s_tdata[68:48];
        ri = (d > floor_reg) ? d : floor_reg;
        side0_next      = '0;
        side0_next.eneg = w[EPS_W-1];
        side0_next.emag = w[EPS_W-1] ? EPS_W'(-w) : w;
        side0_next.big  = (ri == '0) || ({{(D_W-4){1'b0}}, rs[D_W-1:D_W-4]} >= ri);
        side0_next.zf   = (rep_reg && (d >= rs)) || ((cut_reg != '0) && (d >= cut_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side0_reg <= side0_next;
            ri0_reg   <= ri;
            rs0_reg   <= rs;
        end
    end

    lje_div u_div (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v0_reg), .in_rs(rs0_reg), .in_ri(ri0_reg), .in_side(side0_reg),
        .out_valid(dv_v), .out_q(dv_q), .out_side(dv_side)
    );

    always_comb begin
        dv_side_q   = dv_side;
        dv_side_q.q = dv_q;
    end

    lje_mul #(.AW(Q_W), .BW(Q_W)) u_mul_q2 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(dv_v), .in_a(dv_q), .in_b(dv_q), .in_side(dv_side_q),
        .out_valid(m1_v), .out_p(m1_p), .out_side(m1_s)
    );

    lje_mul #(.AW(Q_W), .BW(Q_W)) u_mul_q3 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(g1_v_reg), .in_a(q2_reg), .in_b(g1_side_reg.q), .in_side(g1_side_reg),
        .out_valid(m2_v), .out_p(m2_p), .out_side(m2_s)
    );

    lje_mul #(.AW(Q_W), .BW(Q_W)) u_mul_x (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(g2_v_reg), .in_a(q3_reg), .in_b(q3_reg), .in_side(g2_side_reg),
        .out_valid(m3_v), .out_p(m3_p), .out_side(m3_s)
    );

    lje_mul #(.AW(X16_W), .BW(X16_W)) u_mul_s (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(g3_v_reg), .in_a(g3_side_reg.x16), .in_b(g3_side_reg.x16),
        .in_side(g3_side_reg),
        .out_valid(m4_v), .out_p(m4_p), .out_side(m4_s)
    );

    lje_mul #(.AW(EPS_W), .BW(TM_W)) u_mul_e (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(g4_v_reg), .in_a(g4_side_reg.emag), .in_b(g4_side_reg.tm),
        .in_side(g4_side_reg),
        .out_valid(m5_v), .out_p(m5_p), .out_side(m5_s)
    );

    always_comb begin
        g1_next     = m1_s;
        g1_next.big = m1_s.big | (|m1_p[2*Q_W-1:84]);
        g2_next     = m2_s;
        g2_next.big = m2_s.big | (|m2_p[2*Q_W-1:84]);
        g3_next     = m3_s;
        g3_next.big = m3_s.big | (|m3_p[2*Q_W-1:84]);
        g3_next.x16 = m3_p[83:48];
        s_val       = m4_p[71:16];
        two         = TM_W'({m4_s.x16, 1'b0});
        g4_next      = m4_s;
        g4_next.tneg = s_val < two;
        g4_next.tm   = (s_val < two) ? (two - s_val) : (s_val - two);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g1_v_reg <= 1'b0;
            g2_v_reg <= 1'b0;
            g3_v_reg <= 1'b0;
            g4_v_reg <= 1'b0;
        end else if (en) begin
            g1_v_reg <= m1_v;
            g2_v_reg <= m2_v;
            g3_v_reg <= m3_v;
            g4_v_reg <= m4_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            g1_side_reg <= g1_next;
            q2_reg      <= m1_p[83:32];
            g2_side_reg <= g2_next;
            q3_reg      <= m2_p[83:32];
            g3_side_reg <= g3_next;
            g4_side_reg <= g4_next;
        end
    end

    always_comb begin
        mag = m5_p[EPS_W+TM_W-1:16];
        neg = (m5_s.eneg ^ m5_s.tneg) && (mag != '0);
        if (m5_s.big) begin
            if (m5_s.emag == '0) begin
                res = '0;
            end else if (m5_s.eneg) begin
                res = E_MIN;
            end else begin
                res = E_MAX;
            end
        end else if (neg) begin
            res = (mag > MAG_W'(E_MIN)) ? E_MIN : E_W'(-mag);
        end else begin
            res = (mag > MAG_W'(E_MAX)) ? E_MAX : mag[E_W-1:0];
        end
        if (m5_s.zf) begin
            res = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= m5_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= res;
        end
    end

endmodule

/* hdl/lje_div.sv */
// Pipelined restoring divider: one quotient bit per stage, q = rs * 2^32 / ri
module lje_div
    import lje_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [D_W-1:0]   in_rs,
    input  logic [D_W-1:0]   in_ri,
    input  side_t            in_side,
    output logic             out_valid,
    output logic [Q_W-1:0]   out_q,
    output side_t            out_side
);

    logic [D_W-1:0] rem_reg  [0:Q_W-1];
    logic [D_W-1:0] ri_reg   [0:Q_W-1];
    logic [D_W-1:0] rs_reg   [0:Q_W-1];
    logic [Q_W-1:0] q_reg    [0:Q_W-1];
    side_t          side_reg [0:Q_W-1];
    logic           vld_reg  [0:Q_W-1];

    for (genvar i = 0; i < Q_W; i++) begin : g_stage
        localparam int J = Q_W - 1 - i;
        logic [D_W-1:0] rem_p, ri_p, rs_p, rem_next;
        logic [Q_W-1:0] q_p, q_next;
        side_t          side_p;
        logic           v_p, nbit, ge;
        logic [D_W:0]   trial;

        if (i == 0) begin : g_first
            assign rem_p  = {{(D_W-4){1'b0}}, in_rs[D_W-1:D_W-4]};
            assign ri_p   = in_ri;
            assign rs_p   = in_rs;
            assign q_p    = '0;
            assign side_p = in_side;
            assign v_p    = in_valid;
        end else begin : g_next
            assign rem_p  = rem_reg[i-1];
            assign ri_p   = ri_reg[i-1];
            assign rs_p   = rs_reg[i-1];
            assign q_p    = q_reg[i-1];
            assign side_p = side_reg[i-1];
            assign v_p    = vld_reg[i-1];
        end

        if (J >= 32) begin : g_bit
            assign nbit = rs_p[J-32];
        end else begin : g_zero
            assign nbit = 1'b0;
        end

        always_comb begin
            trial    = {rem_p, nbit};
            ge       = (trial >= {1'b0, ri_p});
            rem_next = ge ? D_W'(trial - {1'b0, ri_p}) : trial[D_W-1:0];
            q_next   = q_p;
            q_next[J] = ge;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= v_p;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= rem_next;
                ri_reg[i]   <= ri_p;
                rs_reg[i]   <= rs_p;
                q_reg[i]    <= q_next;
                side_reg[i] <= side_p;
            end
        end
    end

    assign out_valid = vld_reg[Q_W-1];
    assign out_q     = q_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

/* hdl/lje_mul.sv */
// Two-stage multiplier built from four registered partial products
module lje_mul
    import lje_pkg::*;
#(
    parameter int AW = 52,
    parameter int BW = 52
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [AW-1:0]    in_a,
    input  logic [BW-1:0]    in_b,
    input  side_t            in_side,
    output logic             out_valid,
    output logic [AW+BW-1:0] out_p,
    output side_t            out_side
);

    localparam int AL = (AW + 1) / 2;
    localparam int AH = AW - AL;
    localparam int BL = (BW + 1) / 2;
    localparam int BH = BW - BL;
    localparam int PW = AW + BW;

    logic [AL+BL-1:0] ll_reg;
    logic [AL+BH-1:0] lh_reg;
    logic [AH+BL-1:0] hl_reg;
    logic [AH+BH-1:0] hh_reg;
    side_t            side1_reg, side2_reg;
    logic             v1_reg, v2_reg;
    logic [PW-1:0]    p_reg, p_next;

    always_comb begin
        p_next = (PW'(hh_reg) << (AL + BL)) + (PW'(hl_reg) << AL)
               + (PW'(lh_reg) << BL) + PW'(ll_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg    <= in_a[AL-1:0] * in_b[BL-1:0];
            lh_reg    <= in_a[AL-1:0] * in_b[BW-1:BL];
            hl_reg    <= in_a[AW-1:AL] * in_b[BL-1:0];
            hh_reg    <= in_a[AW-1:AL] * in_b[BW-1:BL];
            side1_reg <= in_side;
            p_reg     <= p_next;
            side2_reg <= side1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_p     = p_reg;
    assign out_side  = side2_reg;

endmodule

/* hdl/lje_chk.sv */
// Port-level checker for the pair energy pipeline, bound to the top level
`include "assert_macros.svh"

module lje_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    `LJE_ASSERT_NR(a_reset_empty, aclk, !aresetn |=> !m_tvalid)
    `LJE_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    `LJE_ASSERT(a_ready_follows, aclk, aresetn, m_tready |-> s_tready)
    `LJE_ASSERT(a_ready_empty, aclk, aresetn, !m_tvalid |-> s_tready)

endmodule

bind lj_pair_energy lje_chk u_lje_chk (.*);
